// ===== hw/rtl/lbr_pkg.sv =====
package lbr_pkg;

   // Generator constants.
   localparam logic [31:0] LCG_MULT  = 32'h015A_4E35;
   localparam logic [31:0] LCG_INC   = 32'd1;
   localparam logic [31:0] LOW_LIMIT = 32'h0000_7FFF;
   localparam int unsigned LOW_SHIFT = 16;

   // Remainder unit: one quotient bit per cycle over a 32-bit dividend.
   localparam int unsigned DIV_STEPS   = 32;
   localparam int unsigned DIV_COUNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_ADVANCE = 2'd2
   } lbr_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_REDUCE,
      ST_DIV_WAIT,
      ST_DONE
   } lbr_state_type;

   // Start request to the remainder unit.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [30:0] divisor;
   } lbr_div_req_type;

   // Completion report from the remainder unit.
   typedef struct packed {
      logic        done;
      logic [30:0] remainder;
   } lbr_div_rsp_type;

endpackage

// ===== hw/rtl/lbr_rem_unit.sv =====
// Restoring remainder unit: one shift, compare and subtract per cycle.
module lbr_rem_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  lbr_pkg::lbr_div_req_type div_req,
   output lbr_pkg::lbr_div_rsp_type div_rsp
);

   logic [30:0]                      rem_ff, rem_in;
   logic [31:0]                      dvd_ff, dvd_in;
   logic [30:0]                      divisor_ff, divisor_in;
   logic [lbr_pkg::DIV_COUNT_W-1:0]  count_ff, count_in;
   logic                             running_ff, running_in;
   logic                             done_ff, done_in;

   logic [31:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[31]};
      diff  = {1'b0, trial} - {2'b00, divisor_ff};

      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         rem_in     = '0;
         dvd_in     = div_req.dividend;
         divisor_in = div_req.divisor;
         count_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         // The partial remainder stays below the divisor, so 31 bits hold it.
         rem_in   = diff[32] ? trial[30:0] : diff[30:0];
         dvd_in   = {dvd_ff[30:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == lbr_pkg::DIV_COUNT_W'(lbr_pkg::DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/lcg_bounded_random_top.sv =====
// Bounded random generator around a 32-bit linear congruential generator.
// The seed register steps as seed * 0x015A4E35 + 1 modulo 2^32. A load request
// writes the seed, an advance request steps it, and a draw request steps it and
// returns the magnitude of the new seed (read as signed) reduced modulo the
// limit; for a limit below 0x7FFF the magnitude is first shifted right by 16.
// A draw with a zero or negative limit returns 0 and keeps the seed, as does
// the unused command code three. Every request yields exactly one response that
// carries the seed after the request. The block handles one request at a time
// and holds req_ready low while it works. A load passes from the accepting
// state straight to the hand-over state; an advance passes the multiply step
// first. A draw with a positive limit passes the multiply step, launches the
// reduction in a restoring unit that settles one bit per cycle over the 32
// dividend bits, collects the remainder and then loads the response register.
// A finished response waits in the output register for rsp_ready while the
// block already takes the next request; the block waits to deliver a second
// response only if the first is still held there.
module lcg_bounded_random_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_random_value,
   output logic [31:0] rsp_current_seed
);

   lbr_pkg::lbr_state_type state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [30:0] limit_ff, limit_in;
   logic        small_ff, small_in;
   logic [31:0] seed_ff, seed_in;
   logic [30:0] rv_ff, rv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_random_value_ff, rsp_random_value_in;
   logic [31:0] rsp_current_seed_ff, rsp_current_seed_in;

   logic        accept;
   logic        limit_positive;
   logic [31:0] seed_step;
   logic [31:0] seed_mag;

   lbr_pkg::lbr_div_req_type div_req;
   lbr_pkg::lbr_div_rsp_type div_rsp;

   lbr_rem_unit u_rem_unit (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == lbr_pkg::ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   // A limit is usable only when it is nonzero and its sign bit is clear.
   assign limit_positive = !req_limit[31] && (req_limit != '0);

   // The product is kept modulo 2^32.
   assign seed_step = seed_ff * lbr_pkg::LCG_MULT + lbr_pkg::LCG_INC;

   // Negating the most negative seed gives 0x80000000, which is its magnitude.
   assign seed_mag = seed_ff[31] ? (32'd0 - seed_ff) : seed_ff;

   always_comb begin
      state_in            = state_ff;
      cmd_in              = cmd_ff;
      limit_in            = limit_ff;
      small_in            = small_ff;
      seed_in             = seed_ff;
      rv_in               = rv_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_random_value_in = rsp_random_value_ff;
      rsp_current_seed_in = rsp_current_seed_ff;
      div_req.start       = 1'b0;
      div_req.dividend    = small_ff ? {16'd0, seed_mag[31:lbr_pkg::LOW_SHIFT]} : seed_mag;
      div_req.divisor     = limit_ff;

      case (state_ff)
         lbr_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               limit_in = req_limit[30:0];
               small_in = req_limit < lbr_pkg::LOW_LIMIT;
               rv_in    = '0;
               case (req_command)
                  lbr_pkg::CMD_LOAD: begin
                     seed_in  = req_seed_value;
                     state_in = lbr_pkg::ST_DONE;
                  end
                  lbr_pkg::CMD_DRAW: begin
                     state_in = limit_positive ? lbr_pkg::ST_STEP : lbr_pkg::ST_DONE;
                  end
                  lbr_pkg::CMD_ADVANCE: begin
                     state_in = lbr_pkg::ST_STEP;
                  end
                  default: begin
                     state_in = lbr_pkg::ST_DONE;
                  end
               endcase
            end
         end
         lbr_pkg::ST_STEP: begin
            seed_in = seed_step;
            if (cmd_ff == lbr_pkg::CMD_DRAW) begin
               state_in = lbr_pkg::ST_REDUCE;
            end else begin
               state_in = lbr_pkg::ST_DONE;
            end
         end
         lbr_pkg::ST_REDUCE: begin
            div_req.start = 1'b1;
            state_in      = lbr_pkg::ST_DIV_WAIT;
         end
         lbr_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               rv_in    = div_rsp.remainder;
               state_in = lbr_pkg::ST_DONE;
            end
         end
         lbr_pkg::ST_DONE: begin
            // Hand over once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_random_value_in = rv_ff;
               rsp_current_seed_in = seed_ff;
               state_in            = lbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbr_pkg::ST_IDLE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff              <= cmd_in;
      limit_ff            <= limit_in;
      small_ff            <= small_in;
      rv_ff               <= rv_in;
      rsp_random_value_ff <= rsp_random_value_in;
      rsp_current_seed_ff <= rsp_current_seed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_random_value_ff;
   assign rsp_current_seed = rsp_current_seed_ff;

endmodule

// ===== hw/rtl/lbr_checker.sv =====
module lbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic [31:0] req_seed_value,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_random_value,
   input logic [31:0] rsp_current_seed
);

   // Only one request is in flight at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in flight");

   // Between a request being taken and its response rising, the block passes through the hand-over state.
   a_no_early_response: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after its request");

   // A load into an empty output register shows the loaded seed after the hand-over state loads the response register.
   a_load_response: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == lbr_pkg::CMD_LOAD && !rsp_valid)
      |=> ##1 (rsp_valid && rsp_random_value == '0
               && rsp_current_seed == $past(req_seed_value, 2)))
      else $error("load response missing or wrong");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_current_seed)
                                     && $stable(rsp_random_value)))
      else $error("stalled response changed");

endmodule

bind lcg_bounded_random_top lbr_checker u_lbr_checker (.*);
